[hdl/ptds_pkg.sv]
`timescale 1ns / 1ps

package ptds_pkg;

  // Default width of the phase timer
  localparam int TimerBitsDef = 16;

  // Width of the tick-count time limits held in configuration
  localparam int LimitW = 16;

  // Servo pulse widths in microseconds
  localparam logic [11:0] PulseStop = 12'd1500;
  localparam logic [11:0] PulseWind = 12'd2500;

  // Configuration register indexes
  localparam logic [2:0] CfgThreshold = 3'd0;
  localparam logic [2:0] CfgUpPulse   = 3'd1;
  localparam logic [2:0] CfgDownPulse = 3'd2;
  localparam logic [2:0] CfgWindSec   = 3'd3;
  localparam logic [2:0] CfgCountdown = 3'd4;
  localparam logic [2:0] CfgPostDrop  = 3'd5;
  localparam logic [2:0] CfgSettle    = 3'd6;

  // Configuration reset values
  localparam logic [9:0]  RstThreshold = 10'd50;
  localparam logic [11:0] RstUpPulse   = 12'd2000;
  localparam logic [11:0] RstDownPulse = 12'd1000;
  localparam logic [5:0]  RstWindSec   = 6'd1;
  localparam logic [15:0] RstCountdown = 16'd2000;
  localparam logic [15:0] RstPostDrop  = 16'd3000;
  localparam logic [15:0] RstSettle    = 16'd1000;

  typedef enum logic [2:0] {
    FuncTick     = 3'd0,
    FuncAutoOn   = 3'd1,
    FuncAutoOff  = 3'd2,
    FuncDrop     = 3'd3,
    FuncLift     = 3'd4,
    FuncLiftWind = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    PhIdle       = 3'd0,
    PhWatch      = 3'd1,
    PhWaitClear  = 3'd2,
    PhCountdown  = 3'd3,
    PhDropSettle = 3'd4,
    PhPostDrop   = 3'd5,
    PhLiftSettle = 3'd6,
    PhWind       = 3'd7
  } phase_e;

  typedef enum logic [3:0] {
    EvNone       = 4'd0,
    EvAutoOn     = 4'd1,
    EvDetected   = 4'd2,
    EvCountStart = 4'd3,
    EvAborted    = 4'd4,
    EvDropping   = 4'd5,
    EvReturned   = 4'd6,
    EvRearming   = 4'd7,
    EvWindStart  = 4'd8,
    EvWindStop   = 4'd9,
    EvManual     = 4'd10
  } event_e;

  typedef struct packed {
    logic [9:0]  threshold;
    logic [11:0] up_pulse;
    logic [11:0] down_pulse;
    logic [5:0]  wind_sec;
    logic [15:0] countdown;
    logic [15:0] post_drop;
    logic [15:0] settle;
  } cfg_t;

  typedef struct packed {
    event_e      event_res;
    logic        auto_active;
    logic        armed;
    phase_e      phase;
    logic [11:0] wind_pulse_us;
    logic [11:0] lift_pulse_us;
  } res_t;

endpackage

[hdl/ptds_seq.sv]
`timescale 1ns / 1ps

module ptds_seq import ptds_pkg::*; #(
  parameter int TIMER_BITS = TimerBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [2:0] func_i,
  input  logic [9:0] distance_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  localparam int CmpW = (TIMER_BITS > LimitW) ? TIMER_BITS : LimitW;
  localparam logic [TIMER_BITS-1:0] TMax = {TIMER_BITS{1'b1}};

  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic                  armed_q, armed_d;
  logic                  auto_q, auto_d;
  logic                  wal_q, wal_d;
  logic [11:0]           lift_q, lift_d;
  logic [11:0]           wind_q, wind_d;
  event_e                ev;

  logic [TIMER_BITS-1:0] timer_inc;
  logic [LimitW-1:0]     wind_lim;
  logic                  present;
  logic                  hit_cd, hit_post, hit_settle, hit_wind;

  // Saturating timer advance; a limit past the top is met at saturation
  function automatic logic reached(input logic [TIMER_BITS-1:0] t,
                                   input logic [LimitW-1:0] limit);
    reached = (CmpW'(t) >= CmpW'(limit)) || (t == TMax);
  endfunction

  assign timer_inc  = (timer_q == TMax) ? timer_q : timer_q + TIMER_BITS'(1);
  // Seconds to ticks: times 1024 less 16 less 8
  assign wind_lim   = {cfg_i.wind_sec, 10'd0} - LimitW'({cfg_i.wind_sec, 4'd0})
                      - LimitW'({cfg_i.wind_sec, 3'd0});
  assign present    = distance_i < cfg_i.threshold;
  assign hit_cd     = reached(timer_inc, cfg_i.countdown);
  assign hit_post   = reached(timer_inc, cfg_i.post_drop);
  assign hit_settle = reached(timer_inc, cfg_i.settle);
  assign hit_wind   = reached(timer_inc, wind_lim);

  // Next state for one transaction
  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    armed_d = armed_q;
    auto_d  = auto_q;
    wal_d   = wal_q;
    lift_d  = lift_q;
    wind_d  = wind_q;
    ev      = EvNone;
    if (step_i) begin
      case (func_i)
        FuncTick: begin
          case (phase_q)
            PhWatch: begin
              if (present) begin
                phase_d = PhWaitClear;
                timer_d = '0;
                ev      = EvDetected;
              end
            end
            PhWaitClear: begin
              if (!present) begin
                phase_d = PhCountdown;
                timer_d = '0;
                ev      = EvCountStart;
              end
            end
            PhCountdown: begin
              if (present) begin
                phase_d = PhWaitClear;
                timer_d = '0;
                ev      = EvAborted;
              end else if (hit_cd) begin
                lift_d  = cfg_i.down_pulse;
                armed_d = 1'b0;
                phase_d = PhDropSettle;
                timer_d = '0;
                ev      = EvDropping;
              end else begin
                timer_d = timer_inc;
              end
            end
            PhDropSettle: begin
              if (hit_settle) begin
                phase_d = auto_q ? PhPostDrop : PhIdle;
                timer_d = '0;
              end else begin
                timer_d = timer_inc;
              end
            end
            PhPostDrop: begin
              if (present) begin
                phase_d = PhWatch;
                timer_d = '0;
                ev      = EvReturned;
              end else if (hit_post) begin
                lift_d  = cfg_i.up_pulse;
                wal_d   = 1'b1;
                phase_d = PhLiftSettle;
                timer_d = '0;
                ev      = EvRearming;
              end else begin
                timer_d = timer_inc;
              end
            end
            PhLiftSettle: begin
              if (hit_settle) begin
                timer_d = '0;
                if (wal_q) begin
                  wind_d  = PulseWind;
                  phase_d = PhWind;
                  ev      = EvWindStart;
                end else begin
                  phase_d = auto_q ? PhWatch : PhIdle;
                end
              end else begin
                timer_d = timer_inc;
              end
            end
            PhWind: begin
              if (hit_wind) begin
                wind_d  = PulseStop;
                armed_d = 1'b1;
                wal_d   = 1'b0;
                phase_d = auto_q ? PhWatch : PhIdle;
                timer_d = '0;
                ev      = EvWindStop;
              end else begin
                timer_d = timer_inc;
              end
            end
            default: ;
          endcase
        end
        FuncAutoOn: begin
          if (phase_q == PhIdle) begin
            auto_d  = 1'b1;
            timer_d = '0;
            ev      = EvAutoOn;
            if (armed_q) begin
              phase_d = PhWatch;
            end else begin
              lift_d  = cfg_i.up_pulse;
              wal_d   = 1'b1;
              phase_d = PhLiftSettle;
            end
          end
        end
        FuncAutoOff: begin
          auto_d = 1'b0;
          ev     = EvManual;
          if (phase_q == PhWatch || phase_q == PhWaitClear ||
              phase_q == PhCountdown || phase_q == PhPostDrop) begin
            phase_d = PhIdle;
            timer_d = '0;
          end
        end
        FuncDrop: begin
          if (phase_q == PhIdle) begin
            lift_d  = cfg_i.down_pulse;
            armed_d = 1'b0;
            phase_d = PhDropSettle;
            timer_d = '0;
            ev      = EvManual;
          end
        end
        FuncLift, FuncLiftWind: begin
          if (phase_q == PhIdle) begin
            lift_d  = cfg_i.up_pulse;
            wal_d   = (func_i == FuncLiftWind);
            phase_d = PhLiftSettle;
            timer_d = '0;
            ev      = EvManual;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      timer_q <= '0;
      armed_q <= 1'b0;
      auto_q  <= 1'b0;
      wal_q   <= 1'b0;
      lift_q  <= PulseStop;
      wind_q  <= PulseStop;
    end else begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      armed_q <= armed_d;
      auto_q  <= auto_d;
      wal_q   <= wal_d;
      lift_q  <= lift_d;
      wind_q  <= wind_d;
    end
  end

  assign res_o.lift_pulse_us = lift_d;
  assign res_o.wind_pulse_us = wind_d;
  assign res_o.phase         = phase_d;
  assign res_o.armed         = armed_d;
  assign res_o.auto_active   = auto_d;
  assign res_o.event_res     = ev;

endmodule

[hdl/presence_triggered_drop_sequencer.sv]
`timescale 1ns / 1ps

// Channel   Direction  Contents
// s_axis    in         tuser: func; tdata: distance
// m_axis    out        tdata: lift pulse, wind pulse, phase, armed, auto, event
// cfg       in         register index and write data
//
// One transaction per cycle unless output is held; results are registered.
// The output register holds a result while m_axis_tready_i is low, and
// s_axis_tready_o follows it so a new input is taken as the result leaves.
// Reset returns the sequencer to idle with servos stopped and loads register
// defaults; configuration writes are always ready.

module presence_triggered_drop_sequencer import ptds_pkg::*; #(
  parameter int TIMER_BITS = TimerBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [9:0] distance
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [11:0] lift_pulse_us, [23:12] wind_pulse_us, [26:24] phase,
  // [27] armed, [28] auto_active, [32:29] event_res
  output logic [39:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg_q;
  res_t res, res_q;
  logic out_valid_q;
  logic in_acc;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Store configuration writes, masked to register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= RstThreshold;
      cfg_q.up_pulse   <= RstUpPulse;
      cfg_q.down_pulse <= RstDownPulse;
      cfg_q.wind_sec   <= RstWindSec;
      cfg_q.countdown  <= RstCountdown;
      cfg_q.post_drop  <= RstPostDrop;
      cfg_q.settle     <= RstSettle;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgThreshold: cfg_q.threshold  <= cfg_data_i[9:0];
        CfgUpPulse:   cfg_q.up_pulse   <= cfg_data_i[11:0];
        CfgDownPulse: cfg_q.down_pulse <= cfg_data_i[11:0];
        CfgWindSec:   cfg_q.wind_sec   <= cfg_data_i[5:0];
        CfgCountdown: cfg_q.countdown  <= cfg_data_i;
        CfgPostDrop:  cfg_q.post_drop  <= cfg_data_i;
        CfgSettle:    cfg_q.settle     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ptds_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_acc),
    .func_i     (s_axis_tuser_i),
    .distance_i (s_axis_tdata_i[9:0]),
    .cfg_i      (cfg_q),
    .res_o      (res)
  );

  // Track the output register occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_acc || (out_valid_q && !m_axis_tready_i);
    end
  end

  // Capture the result of each accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, res_q};

endmodule
